FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also runs during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

FILE: rtl/lmfs_pkg.sv
// Types and constants shared by the LED matrix frame serializer modules.
`default_nettype none

package lmfs_pkg;

    // Command codes of an input word.
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_SHIFT = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_FLUSH = 3'd3;
    localparam logic [2:0] CMD_BCAST = 3'd4;

    // Frame geometry.
    localparam int NUM_SLOTS = 4;
    localparam int ROWS      = 8;
    localparam logic [2:0]  LAST_ROW  = 3'd7;
    localparam logic [15:0] NOOP_WORD = 16'h0000;

    typedef logic [15:0] t_word;

    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] column_index;
        logic [7:0] data;
        logic [7:0] register_address;
    } t_in_item;

    typedef struct packed {
        logic [15:0] word_slot0;
        logic [15:0] word_slot1;
        logic [15:0] word_slot2;
        logic [15:0] word_slot3;
        logic        last_frame;
    } t_out_item;

    // A command that has passed the decoder, waiting in the queue.
    typedef struct packed {
        logic [2:0] cmd;
        logic [4:0] column_index;
        logic [7:0] data;
        logic [7:0] register_address;
    } t_job;

    // Queue status seen by the decoder and the executor.
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

FILE: rtl/lmfs_front.sv
// Command decoder: accepts input words and drops those that do nothing.
`default_nettype none

module lmfs_front import lmfs_pkg::*; #(
    parameter int DEVICES = 4
) (
    input  logic      i_start,
    input  t_in_item  i_item,
    input  t_q_status i_q,
    output logic      o_push,
    output t_job      o_job
);

    localparam int COLS = DEVICES * 8;

    logic known_cmd;
    logic col_ok;

    // Unknown commands and writes beyond the chain are discarded here.
    always_comb begin
        known_cmd = (i_item.cmd == CMD_WRITE) || (i_item.cmd == CMD_SHIFT) ||
                    (i_item.cmd == CMD_CLEAR) || (i_item.cmd == CMD_FLUSH) ||
                    (i_item.cmd == CMD_BCAST);
        col_ok    = ({1'b0, i_item.column_index} < 6'(COLS));
        o_push    = i_start && !i_q.full && known_cmd &&
                    ((i_item.cmd != CMD_WRITE) || col_ok);
    end

    assign o_job.cmd              = i_item.cmd;
    assign o_job.column_index     = i_item.column_index;
    assign o_job.data             = i_item.data;
    assign o_job.register_address = i_item.register_address;

endmodule

`default_nettype wire

FILE: rtl/lmfs_queue.sv
// Two-entry command queue between the decoder and the executor.
`default_nettype none

module lmfs_queue import lmfs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_job       r_head;
    t_job       n_head;
    t_job       r_tail;
    t_job       n_tail;

    // The head entry is always the oldest word; the tail only fills when two wait.
    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_tail  = r_tail;
        case ({i_push, i_pop})
            2'b01: begin
                n_head  = r_tail;
                n_count = r_count - 2'd1;
            end
            2'b10: begin
                if (r_count == 2'd0) begin
                    n_head = i_job;
                end else begin
                    n_tail = i_job;
                end
                n_count = r_count + 2'd1;
            end
            2'b11: begin
                if (r_count == 2'd1) begin
                    n_head = i_job;
                end else begin
                    n_head = r_tail;
                    n_tail = i_job;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_head             = r_head;
    assign o_status.not_empty = (r_count != 2'd0);
    assign o_status.full      = (r_count == 2'd2);

endmodule

`default_nettype wire

FILE: rtl/lmfs_back.sv
// Executor: holds the column store and sends chip-select frames, one a cycle.
`default_nettype none

module lmfs_back import lmfs_pkg::*; #(
    parameter int DEVICES = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  t_q_status i_q,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int COLS     = DEVICES * 8;
    localparam int IDX_W    = $clog2(COLS);
    localparam int DEV_W    = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int LAST_DEV = DEVICES - 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [7:0]       r_store [COLS];
    logic [7:0]       n_store [COLS];
    logic [2:0]       r_row;
    logic [2:0]       n_row;
    logic [DEV_W-1:0] r_dev;
    logic [DEV_W-1:0] n_dev;
    logic             r_valid;
    logic             n_valid;
    t_out_item        r_result;
    t_out_item        n_result;

    logic [7:0] row_byte;
    logic [3:0] digit;
    t_word      words [NUM_SLOTS];

    // Transpose: the row byte takes bit r_row of the eight leading columns.
    // The store is rotated by one device after each device's rows, so the
    // device being sent always sits in columns 0 to 7.
    always_comb begin
        for (int c = 0; c < ROWS; c++) begin
            row_byte[3'(ROWS - 1 - c)] = r_store[c][r_row];
        end
        digit = 4'({1'b0, r_row}) + 4'd1;
    end

    // Slot words for either a flush frame or a broadcast frame.
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (r_state == ST_FLUSH) begin
                words[s] = (2'(s) == 2'(r_dev)) ? {4'b0000, digit, row_byte} : NOOP_WORD;
            end else begin
                words[s] = (s < DEVICES) ? {i_job.register_address, i_job.data}
                                         : NOOP_WORD;
            end
        end
    end

    // Command sequencing and store updates.
    always_comb begin
        n_state  = r_state;
        n_store  = r_store;
        n_row    = r_row;
        n_dev    = r_dev;
        n_valid  = 1'b0;
        n_result = r_result;
        o_pop    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q.not_empty) begin
                    o_pop = 1'b1;
                    case (i_job.cmd)
                        CMD_WRITE: begin
                            n_store[i_job.column_index[IDX_W-1:0]] = i_job.data;
                        end
                        CMD_SHIFT: begin
                            for (int k = 1; k < COLS; k++) begin
                                n_store[k] = r_store[k-1];
                            end
                            n_store[0] = 8'h00;
                            n_state    = ST_FLUSH;
                            n_row      = 3'd0;
                            n_dev      = '0;
                        end
                        CMD_CLEAR: begin
                            for (int k = 0; k < COLS; k++) begin
                                n_store[k] = 8'h00;
                            end
                            n_state = ST_FLUSH;
                            n_row   = 3'd0;
                            n_dev   = '0;
                        end
                        CMD_FLUSH: begin
                            n_state = ST_FLUSH;
                            n_row   = 3'd0;
                            n_dev   = '0;
                        end
                        CMD_BCAST: begin
                            n_valid             = 1'b1;
                            n_result.word_slot0 = words[0];
                            n_result.word_slot1 = words[1];
                            n_result.word_slot2 = words[2];
                            n_result.word_slot3 = words[3];
                            n_result.last_frame = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FLUSH: begin
                n_valid             = 1'b1;
                n_result.word_slot0 = words[0];
                n_result.word_slot1 = words[1];
                n_result.word_slot2 = words[2];
                n_result.word_slot3 = words[3];
                n_result.last_frame = (r_dev == DEV_W'(LAST_DEV)) && (r_row == LAST_ROW);
                n_row               = r_row + 3'd1;
                if (r_row == LAST_ROW) begin
                    // Bring the next device's columns to the front.
                    for (int k = 0; k < COLS; k++) begin
                        n_store[k] = r_store[(k + ROWS) % COLS];
                    end
                    if (r_dev == DEV_W'(LAST_DEV)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_dev = r_dev + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= 3'd0;
            r_dev   <= '0;
            r_valid <= 1'b0;
            for (int k = 0; k < COLS; k++) begin
                r_store[k] <= 8'h00;
            end
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_dev   <= n_dev;
            r_valid <= n_valid;
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/led_matrix_frame_serializer.sv
// Top level of the frame serializer for a chain of 8x8 LED matrix drivers.
//
// Input channel: a command word on i_item is taken at a rising edge where
// start is high and busy is low. Writes to columns beyond the chain and
// unknown command codes are taken and dropped.
// Output channel: each chip-select frame appears on o_result for exactly one
// cycle with o_valid high; the receiver has no way to hold it off.
// A decoder puts each command into a two-entry queue, and busy is high while
// that queue is full. The executor takes one command at a time from it.
// Sequence, with the executor idle: a taken command is registered in the
// queue until the executor pops it. A column write only updates the store.
// A broadcast frame is registered on o_result as its command is popped. A
// flush (plain, after a shift or after a clear) enters the flush state, then
// sends DEVICES*8 frames on consecutive cycles; the single frame builder,
// one row per cycle, keeps the executor from popping until the last frame.
// Reset clears the column store, the queue and the output strobe at once.
`default_nettype none

module led_matrix_frame_serializer import lmfs_pkg::*; #(
    parameter int DEVICES = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    logic      push;
    logic      pop;
    t_job      push_job;
    t_job      head_job;
    t_q_status q_status;

    // Decoder.
    lmfs_front #(
        .DEVICES (DEVICES)
    ) u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_q     (q_status),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Command queue.
    lmfs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    // Executor.
    lmfs_back #(
        .DEVICES (DEVICES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_q      (q_status),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    assign busy = q_status.full;

endmodule

`default_nettype wire

FILE: rtl/lmfs_checker.sv
// Port-level checker for the frame serializer and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module lmfs_checker import lmfs_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      busy,
    input logic      o_valid,
    input t_out_item o_result
);

    logic [3:0] slot_addressed;

    // A slot addresses a device when its digit field is not zero.
    assign slot_addressed = {o_result.word_slot0[11:8] != 4'd0,
                             o_result.word_slot1[11:8] != 4'd0,
                             o_result.word_slot2[11:8] != 4'd0,
                             o_result.word_slot3[11:8] != 4'd0};

    // The frames of one flush follow each other with no gap.
    `ASSERT_CLKD(a_flush_contiguous, i_clk, i_rst_n, o_valid && !o_result.last_frame |=> o_valid)

    // Any frame that is not the last of its command addresses exactly one device.
    `ASSERT_CLKD(a_single_target, i_clk, i_rst_n, o_valid && !o_result.last_frame |-> $countones(slot_addressed) == 1)

    // Reset leaves no frame on the port and the input open.
    `ASSERT_CLK_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !busy)

endmodule

bind led_matrix_frame_serializer lmfs_checker u_checker (.*);

`default_nettype wire
